// ===== rtl/sacl_pkg.sv =====
// Shared types and constants of the set-associative cache lookup block.
package sacl_pkg;

	// Fixed widths of the entry count and result fields
	localparam int unsigned CNT_W  = 16;
	localparam int unsigned VTAG_W = 19;
	localparam int unsigned OWAY_W = 2;
	localparam int unsigned RES_W  = 24;

	// Configuration register indexes and values
	localparam logic [7:0] REG_REPLACE = 8'd0;
	localparam logic [7:0] REG_WRITE   = 8'd1;
	localparam logic POL_LRU = 1'b0;
	localparam logic POL_LFU = 1'b1;
	localparam logic WP_WRITE_BACK = 1'b0;
	localparam logic WP_WRITE_THRU = 1'b1;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP
	} ctrl_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic clear_step;
		logic accept;
		logic commit;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic clear_last;
	} ctrl_sts_t;

endpackage

// ===== rtl/sacl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sacl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/sacl_ctrl.sv =====
// Controller state machine: clearing pass, beat acceptance and commit sequencing.
module sacl_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  sacl_pkg::ctrl_sts_t sts,
	output sacl_pkg::ctrl_cmd_t cmd
);

	import sacl_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR:  if (sts.clear_last) state_d = ST_IDLE;
			ST_IDLE:   if (in_valid) state_d = ST_LOOKUP;
			ST_LOOKUP: if (slot_free) state_d = ST_IDLE;
			default:   state_d = ST_CLEAR;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
			end
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_LOOKUP: begin
				cmd.commit = slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/sacl_dpath.sv =====
// Datapath: set RAM, way compare, victim choice, row update and result register.
module sacl_dpath #(
	parameter int unsigned NUM_SETS    = 256,
	parameter int unsigned NUM_WAYS    = 4,
	parameter int unsigned BLOCK_BYTES = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  sacl_pkg::ctrl_cmd_t cmd,
	output sacl_pkg::ctrl_sts_t sts,
	input  logic [31:0]         in_address,
	input  logic                in_func,
	input  logic                replace_policy,
	input  logic                write_policy,
	output logic [sacl_pkg::RES_W-1:0] result
);

	import sacl_pkg::*;

	localparam int unsigned OFF_W = $clog2(BLOCK_BYTES);
	localparam int unsigned SET_W = $clog2(NUM_SETS);
	localparam int unsigned IDX_W = (SET_W > 0) ? SET_W : 1;
	localparam int unsigned TAG_W = 32 - OFF_W - SET_W;
	localparam int unsigned WAY_W = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int unsigned NV_W  = $clog2(NUM_WAYS + 1);
	localparam int unsigned ENT_W = 2 + CNT_W + WAY_W + TAG_W;
	localparam int unsigned ROW_W = NUM_WAYS * ENT_W;
	// Entry layout from bit 0: valid, dirty, count, rank, tag
	localparam int unsigned CNT_LO  = 2;
	localparam int unsigned RANK_LO = 2 + CNT_W;
	localparam int unsigned TAG_LO  = 2 + CNT_W + WAY_W;

	logic [IDX_W-1:0] clr_cnt_q;
	logic [31:0]      addr_q;
	logic             wr_q;
	logic [RES_W-1:0] res_q;
	logic [IDX_W-1:0] in_set, cur_set;
	logic [TAG_W-1:0] cur_tag;
	logic [ROW_W-1:0] rd_row, new_row, wdata;
	logic [RES_W-1:0] res_d;

	assign in_set  = (SET_W > 0) ? IDX_W'(in_address >> OFF_W) : '0;
	assign cur_set = (SET_W > 0) ? IDX_W'(addr_q >> OFF_W) : '0;
	assign cur_tag = TAG_W'(addr_q >> (OFF_W + SET_W));

	assign sts.clear_last = (clr_cnt_q == IDX_W'(NUM_SETS - 1));
	assign wdata = cmd.clear_step ? '0 : new_row;

	sacl_ram #(
		.WIDTH(ROW_W),
		.DEPTH(NUM_SETS),
		.AW   (IDX_W)
	) u_set_ram (
		.clk    (clk),
		.wr_en  (cmd.commit | cmd.clear_step),
		.wr_addr(cmd.clear_step ? clr_cnt_q : cur_set),
		.wr_data(wdata),
		.rd_en  (cmd.accept),
		.rd_addr(in_set),
		.rd_data(rd_row)
	);

	// Lookup, victim choice and row update
	always_comb begin
		logic             e_val   [NUM_WAYS];
		logic             e_dirty [NUM_WAYS];
		logic [CNT_W-1:0] e_cnt   [NUM_WAYS];
		logic [WAY_W-1:0] e_rank  [NUM_WAYS];
		logic [TAG_W-1:0] e_tag   [NUM_WAYS];
		logic             n_val   [NUM_WAYS];
		logic             n_dirty [NUM_WAYS];
		logic [CNT_W-1:0] n_cnt   [NUM_WAYS];
		logic [WAY_W-1:0] n_rank  [NUM_WAYS];
		logic [TAG_W-1:0] n_tag   [NUM_WAYS];
		logic             hit_f, inv_f;
		logic [WAY_W-1:0] hit_w, inv_w, lru_w, lfu_w, vic;
		logic [NV_W-1:0]  nvalid;
		logic [CNT_W-1:0] vcnt;
		logic             wb;
		logic [VTAG_W-1:0] vtag;
		logic             alloc;
		hit_f  = 1'b0;
		inv_f  = 1'b0;
		hit_w  = '0;
		inv_w  = '0;
		lru_w  = '0;
		lfu_w  = '0;
		vic    = '0;
		nvalid = '0;
		vcnt   = '0;
		wb     = 1'b0;
		vtag   = '0;
		alloc  = 1'b0;
		for (int w = 0; w < NUM_WAYS; w++) begin
			e_val[w]   = rd_row[w*ENT_W];
			e_dirty[w] = rd_row[w*ENT_W + 1];
			e_cnt[w]   = rd_row[w*ENT_W + CNT_LO +: CNT_W];
			e_rank[w]  = rd_row[w*ENT_W + RANK_LO +: WAY_W];
			e_tag[w]   = rd_row[w*ENT_W + TAG_LO +: TAG_W];
			n_val[w]   = e_val[w];
			n_dirty[w] = e_dirty[w];
			n_cnt[w]   = e_cnt[w];
			n_rank[w]  = e_rank[w];
			n_tag[w]   = e_tag[w];
		end
		// Way compare, first free way, population
		for (int w = NUM_WAYS - 1; w >= 0; w--) begin
			if (e_val[w]) begin
				if (e_tag[w] == cur_tag) begin
					hit_f = 1'b1;
					hit_w = WAY_W'(w);
				end
			end else begin
				inv_f = 1'b1;
				inv_w = WAY_W'(w);
			end
			// in a full set the ranks form a permutation, so rank zero is unique
			if (e_rank[w] == '0) lru_w = WAY_W'(w);
		end
		for (int w = 0; w < NUM_WAYS; w++) begin
			nvalid = nvalid + NV_W'(e_val[w]);
		end
		// Least count, lowest way on ties
		for (int w = 1; w < NUM_WAYS; w++) begin
			if (e_cnt[w] < e_cnt[lfu_w]) lfu_w = WAY_W'(w);
		end

		if (hit_f) begin
			n_cnt[hit_w] = (e_cnt[hit_w] == '1) ? e_cnt[hit_w] : e_cnt[hit_w] + 1'b1;
			for (int w = 0; w < NUM_WAYS; w++) begin
				if (WAY_W'(w) != hit_w && e_val[w] && e_rank[w] > e_rank[hit_w])
					n_rank[w] = e_rank[w] - 1'b1;
			end
			n_rank[hit_w] = WAY_W'(nvalid - 1'b1);
			if (wr_q && write_policy == WP_WRITE_BACK) n_dirty[hit_w] = 1'b1;
			vic = hit_w;
		end else if (!(wr_q && write_policy == WP_WRITE_THRU)) begin
			alloc = 1'b1;
			if (inv_f) begin
				vic = inv_w;
				n_rank[vic] = WAY_W'(nvalid);
			end else begin
				vic = (replace_policy == POL_LFU) ? lfu_w : lru_w;
				if (e_dirty[vic]) begin
					wb   = 1'b1;
					vtag = VTAG_W'(e_tag[vic]);
				end
				for (int w = 0; w < NUM_WAYS; w++) begin
					if (WAY_W'(w) != vic && e_rank[w] > e_rank[vic])
						n_rank[w] = e_rank[w] - 1'b1;
				end
				n_rank[vic] = WAY_W'(NUM_WAYS - 1);
			end
			vcnt         = e_cnt[vic];
			n_tag[vic]   = cur_tag;
			n_val[vic]   = 1'b1;
			n_dirty[vic] = wr_q;
			n_cnt[vic]   = (vcnt == '1) ? vcnt : vcnt + 1'b1;
		end

		for (int w = 0; w < NUM_WAYS; w++) begin
			new_row[w*ENT_W]                      = n_val[w];
			new_row[w*ENT_W + 1]                  = n_dirty[w];
			new_row[w*ENT_W + CNT_LO +: CNT_W]    = n_cnt[w];
			new_row[w*ENT_W + RANK_LO +: WAY_W]   = n_rank[w];
			new_row[w*ENT_W + TAG_LO +: TAG_W]    = n_tag[w];
		end
		res_d = {vtag, wb, (hit_f || alloc) ? OWAY_W'(vic) : OWAY_W'(0), alloc, hit_f};
	end

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (cmd.clear_step) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
		end
	end

	// Access and result registers
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q <= in_address;
			wr_q   <= in_func;
		end
		if (cmd.commit) begin
			res_q <= res_d;
		end
	end

	assign result = res_q;

endmodule

// ===== rtl/set_assoc_cache_lookup_core.sv =====
// Top level of the set-associative cache tag controller.
// A beat on s_* carries one access (byte address, read/write kind in s_tuser) and yields
// exactly one result beat on m_*. Each access first reads the set row from the set RAM,
// then compares the ways, picks a victim and writes the row back; a new access is taken
// only after that write-back, which waits until the result register is free or draining.
// After reset a clearing pass writes every set row with s_tready low; configuration
// writes are taken throughout. Register 0 selects LRU (0) or LFU (1) replacement,
// register 1 write-back/allocate (0) or write-through/no-allocate (1).
module set_assoc_cache_lookup_core #(
	parameter int unsigned NUM_SETS    = 256,
	parameter int unsigned NUM_WAYS    = 4,
	parameter int unsigned BLOCK_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // address[31:0]
	input  logic        s_tuser,   // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // hit, allocated, way[1:0], writeback, victim_tag[18:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	import sacl_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;
	logic      replace_policy_q;
	logic      write_policy_q;

	// Configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replace_policy_q <= POL_LRU;
			write_policy_q   <= WP_WRITE_BACK;
		end else if (cfg_valid) begin
			if (cfg_index == REG_REPLACE) replace_policy_q <= cfg_data[0];
			if (cfg_index == REG_WRITE)   write_policy_q   <= cfg_data[0];
		end
	end

	sacl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sacl_dpath #(
		.NUM_SETS   (NUM_SETS),
		.NUM_WAYS   (NUM_WAYS),
		.BLOCK_BYTES(BLOCK_BYTES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.in_address    (s_tdata),
		.in_func       (s_tuser),
		.replace_policy(replace_policy_q),
		.write_policy  (write_policy_q),
		.result        (m_tdata)
	);

	// A result is never both a hit and a fill
	a_hit_xor_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
		else $error("hit and allocated both set");

	// A writeback only comes with a fill
	a_wb_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[1])
		else $error("writeback without allocation");

	// An accepted beat is followed by a lookup cycle
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("beat accepted during lookup");

	// Commands are mutually exclusive
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_step, cmd.accept, cmd.commit}))
		else $error("overlapping controller commands");

endmodule
